FILE: rtl/dss_pkg.sv
// Shared constants, codes and handshake structs for the drum step sequencer.
// Used by dss_ctrl, dss_datapath and drum_step_sequencer; depends on nothing.
`timescale 1ns / 1ps

package dss_pkg;

    // Pattern geometry.
    localparam int STEPS    = 32;
    localparam int CHANNELS = 3;
    localparam int PADS     = 8;

    // Field and register widths.
    localparam int POS_W      = $clog2(STEPS);
    localparam int CNT_W      = 6;
    localparam int PERIOD_W   = 24;
    localparam int CH_W       = 2;
    localparam int BANK_W     = 2;
    localparam int PAD_W      = 3;
    localparam int KIND_W     = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // Stream word widths.
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_COUNT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_PERIOD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EDIT_CHANNEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_EDIT_BANK    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE    = 3'd4;

    // Reset value of the step count register.
    localparam logic [CNT_W-1:0] STEP_COUNT_RST = CNT_W'(32);

    // Play modes.
    localparam logic MODE_DRUM = 1'b0;
    localparam logic MODE_LOOP = 1'b1;

    // Input word kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_TICK   = 2'd0,
        KIND_PAD    = 2'd1,
        KIND_RECORD = 2'd2,
        KIND_CLEAR  = 2'd3
    } kind_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // accept an input word and read the pattern entry
        logic commit;  // apply the update and load the output register
    } dss_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free; // output register can take a word this cycle
    } dss_stat_t;

endpackage

FILE: rtl/drum_step_sequencer.sv
// Top level of the drum step sequencer: stream ports and config port.
// Depends on dss_pkg, dss_ctrl and dss_datapath.
//
//   Channel   Dir  Ports                          Contents
//   input     in   s_tvalid s_tready s_tdata      pad, hit channel, mute mask
//                  s_tuser                        word kind
//   result    out  m_tvalid m_tready m_tdata      trigger mask, position
//                  m_tuser                        advanced flag
//   config    in   cfg_wr_en cfg_index cfg_wdata  register writes
//
// Each word is first accepted and its pattern entry read; then the pattern,
// position and tick count are updated and the result is loaded.
// The pattern store has a single read port; a new word is taken only once
// the last is committed. A full output register that is not taken holds
// the word before its update; the next word can be accepted while a result waits.
// Reset is synchronous and active low; the pattern reads as empty at once.
`timescale 1ns / 1ps

module drum_step_sequencer import dss_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // input words
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_DATA_W-1:0]   s_tdata,  // [2:0] pad, [4:3] hit_channel, [7:5] mute_mask
    input  logic [KIND_W-1:0]     s_tuser,  // [1:0] kind
    // result words
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_DATA_W-1:0]   m_tdata,  // [2:0] trigger_mask, [7:3] position
    output logic                  m_tuser,  // [0] advanced
    // configuration
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    dss_cmd_t            cmd;
    dss_stat_t           stat;
    logic [CHANNELS-1:0] trigger_mask;
    logic [POS_W-1:0]    position;

    dss_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dss_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_kind          (kind_t'(s_tuser)),
        .in_pad           (s_tdata[2:0]),
        .in_hit_channel   (s_tdata[4:3]),
        .in_mute_mask     (s_tdata[7:5]),
        .cmd              (cmd),
        .stat             (stat),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .out_trigger_mask (trigger_mask),
        .out_advanced     (m_tuser),
        .out_position     (position)
    );

    assign m_tdata = {position, trigger_mask};

endmodule

FILE: rtl/dss_ctrl.sv
// Controller state machine of the drum step sequencer.
// Depends on dss_pkg; drives the commands of dss_datapath.
`timescale 1ns / 1ps

module dss_ctrl import dss_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  dss_stat_t stat,
    output dss_cmd_t  cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Ready only while no word is in flight.
    assign s_tready   = (state_reg == ST_IDLE);
    assign cmd.load   = s_tvalid && s_tready;
    assign cmd.commit = (state_reg == ST_EXEC) && stat.out_free;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.load) state_next = ST_EXEC;
            end
            ST_EXEC: begin
                if (cmd.commit) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // A word that is read must be committed before another is taken.
    a_hold_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EXEC) && !stat.out_free |=> (state_reg == ST_EXEC))
        else $error("controller left EXEC while output was blocked");

    a_load_commit_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.load && cmd.commit))
        else $error("load and commit issued in the same cycle");

endmodule

FILE: rtl/dss_datapath.sv
// Datapath of the drum step sequencer: config registers, pattern store,
// position and tick counter, and the output register. Depends on dss_pkg.
`timescale 1ns / 1ps

module dss_datapath import dss_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    // input word fields
    input  kind_t                 in_kind,
    input  logic [PAD_W-1:0]      in_pad,
    input  logic [CH_W-1:0]       in_hit_channel,
    input  logic [CHANNELS-1:0]   in_mute_mask,
    // control
    input  dss_cmd_t              cmd,
    output dss_stat_t             stat,
    // result word
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [CHANNELS-1:0]   out_trigger_mask,
    output logic                  out_advanced,
    output logic [POS_W-1:0]      out_position
);

    // Configuration registers.
    logic [CNT_W-1:0]    step_count_reg;
    logic [PERIOD_W-1:0] step_period_reg;
    logic [CH_W-1:0]     edit_channel_reg;
    logic [BANK_W-1:0]   edit_bank_reg;
    logic                play_mode_reg;

    // Sequencer state.
    logic [POS_W-1:0]    pos_reg;
    logic [POS_W-1:0]    pos_next;
    logic [PERIOD_W-1:0] tick_count_reg;
    logic [PERIOD_W-1:0] tick_count_next;

    // Pattern store with one valid bit per entry.
    logic [CHANNELS-1:0] pattern_mem [STEPS];
    logic [STEPS-1:0]    valid_reg;

    // Word held between the read and the commit cycles.
    kind_t               kind_reg;
    logic [CH_W-1:0]     hit_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [CHANNELS-1:0] mute_reg;
    logic [POS_W-1:0]    addr_reg;
    logic                adv_reg;
    logic                tick_we_reg;
    logic [PERIOD_W-1:0] tick_val_reg;
    logic [CHANNELS-1:0] rdata_reg;
    logic                rvalid_reg;

    // Output register.
    logic                m_valid_reg;
    logic [CHANNELS-1:0] m_trig_reg;
    logic [CHANNELS-1:0] m_trig_next;
    logic                m_adv_reg;
    logic [POS_W-1:0]    m_pos_reg;

    // Read-side decode.
    logic [CNT_W-1:0]    steps_use;
    logic [CNT_W-1:0]    banks;
    logic [BANK_W-1:0]   bank_sel;
    logic [CH_W-1:0]     ch_sel;
    logic [PERIOD_W-1:0] tick_inc;
    logic                step_hit;
    logic [CNT_W-1:0]    pos_inc;
    logic [POS_W-1:0]    next_pos;
    logic [POS_W-1:0]    pad_step;
    logic [POS_W-1:0]    rd_addr;

    // Commit-side update.
    logic [CHANNELS-1:0] old_entry;
    logic [CHANNELS-1:0] ch_onehot;
    logic [CHANNELS-1:0] hit_onehot;
    logic [CHANNELS-1:0] wr_data;
    logic                mem_we;
    logic                clear_all;

    assign stat.out_free = !m_valid_reg || m_tready;

    // Step count clamped to 1..STEPS.
    always_comb begin
        steps_use = step_count_reg;
        if (step_count_reg == '0) steps_use = CNT_W'(1);
        if (step_count_reg > CNT_W'(STEPS)) steps_use = CNT_W'(STEPS);
    end

    // Pad addressing: bank beyond those in use falls back to bank 0.
    assign banks    = (steps_use + CNT_W'(PADS - 1)) >> $clog2(PADS);
    assign bank_sel = (CNT_W'(edit_bank_reg) < banks) ? edit_bank_reg : '0;
    assign ch_sel   = (edit_channel_reg < CH_W'(CHANNELS)) ? edit_channel_reg : '0;
    assign pad_step = POS_W'({bank_sel, in_pad});

    // Tick counting and position advance.
    assign tick_inc = tick_count_reg + PERIOD_W'(1);
    assign step_hit = (step_period_reg != '0) && (tick_inc >= step_period_reg);
    assign pos_inc  = CNT_W'(pos_reg) + CNT_W'(1);
    assign next_pos = (pos_inc >= steps_use) ? '0 : pos_inc[POS_W-1:0];

    // Pattern address chosen by the word kind.
    always_comb begin
        unique case (in_kind)
            KIND_TICK: rd_addr = next_pos;
            KIND_PAD:  rd_addr = pad_step;
            default:   rd_addr = pos_reg;
        endcase
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_count_reg   <= STEP_COUNT_RST;
            step_period_reg  <= '0;
            edit_channel_reg <= '0;
            edit_bank_reg    <= '0;
            play_mode_reg    <= MODE_DRUM;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_STEP_COUNT:   step_count_reg   <= cfg_wdata[CNT_W-1:0];
                CFG_STEP_PERIOD:  step_period_reg  <= cfg_wdata[PERIOD_W-1:0];
                CFG_EDIT_CHANNEL: edit_channel_reg <= cfg_wdata[CH_W-1:0];
                CFG_EDIT_BANK:    edit_bank_reg    <= cfg_wdata[BANK_W-1:0];
                CFG_PLAY_MODE:    play_mode_reg    <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Capture the word and its decoded update on load.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg     <= in_kind;
            hit_reg      <= in_hit_channel;
            ch_reg       <= ch_sel;
            mute_reg     <= in_mute_mask;
            addr_reg     <= rd_addr;
            adv_reg      <= (in_kind == KIND_TICK) && step_hit;
            tick_we_reg  <= (in_kind == KIND_TICK) && (step_period_reg != '0);
            tick_val_reg <= step_hit ? '0 : tick_inc;
        end
    end

    // Entry contents and update for the commit cycle.
    assign old_entry  = rvalid_reg ? rdata_reg : '0;
    assign ch_onehot  = CHANNELS'(1) << ch_reg;
    assign hit_onehot = CHANNELS'(1) << hit_reg;
    assign clear_all  = cmd.commit && (kind_reg == KIND_CLEAR);

    always_comb begin
        pos_next        = pos_reg;
        tick_count_next = tick_count_reg;
        mem_we          = 1'b0;
        wr_data         = old_entry;
        m_trig_next     = '0;
        unique case (kind_reg)
            KIND_TICK: begin
                if (tick_we_reg) tick_count_next = tick_val_reg;
                if (adv_reg) begin
                    pos_next    = addr_reg;
                    m_trig_next = (play_mode_reg == MODE_LOOP) ?
                                  (old_entry & ~mute_reg) : old_entry;
                end
            end
            KIND_PAD: begin
                mem_we  = 1'b1;
                wr_data = old_entry ^ ch_onehot;
            end
            KIND_RECORD: begin
                mem_we  = (hit_reg < CH_W'(CHANNELS));
                wr_data = old_entry | hit_onehot;
            end
            KIND_CLEAR: begin
                pos_next        = '0;
                tick_count_next = '0;
            end
            default: ;
        endcase
    end

    // Pattern memory: registered read on load, write on commit.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rdata_reg <= pattern_mem[rd_addr];
        end
        if (cmd.commit && mem_we) begin
            pattern_mem[addr_reg] <= wr_data;
        end
    end

    // Valid bits, position and tick counter.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            rvalid_reg     <= 1'b0;
            pos_reg        <= '0;
            tick_count_reg <= '0;
        end else begin
            if (cmd.load) rvalid_reg <= valid_reg[rd_addr];
            if (clear_all) begin
                valid_reg <= '0;
            end else if (cmd.commit && mem_we) begin
                valid_reg[addr_reg] <= 1'b1;
            end
            if (cmd.commit) begin
                pos_reg        <= pos_next;
                tick_count_reg <= tick_count_next;
            end
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.commit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.commit) begin
            m_trig_reg <= m_trig_next;
            m_adv_reg  <= adv_reg;
            m_pos_reg  <= pos_next;
        end
    end

    assign m_tvalid         = m_valid_reg;
    assign out_trigger_mask = m_trig_reg;
    assign out_advanced     = m_adv_reg;
    assign out_position     = m_pos_reg;

    a_clear_rewinds: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_all |=> (pos_reg == '0) && (tick_count_reg == '0) && (valid_reg == '0))
        else $error("clear did not rewind the sequencer");

    a_advance_resets_count: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit && adv_reg |=> (tick_count_reg == '0) && m_adv_reg)
        else $error("step advance did not restart the tick count");

    a_quiet_without_advance: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_adv_reg |-> (m_trig_reg == '0))
        else $error("trigger mask set on a word without an advance");

endmodule
